// ===== rtl/core/cpp_pkg.sv =====
// ----------------------------------------------------------------------------
// cpp_pkg
// Shared types and constants for the command packet parser: parse phases,
// reply kinds, register indexes, configuration and reply word layouts.
// ----------------------------------------------------------------------------
package cpp_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned WAIT_W     = 32;
  // payload bytes that the decoder looks at; later bytes are counted only
  localparam int unsigned HEAD_BYTES = 4;
  localparam int unsigned HEAD_IDX_W = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_START_CODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PING_CODE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_CODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_CODE    = 3'd4;

  // register reset values
  localparam logic [BYTE_W-1:0] RST_START_CODE    = 8'd1;
  localparam logic [BYTE_W-1:0] RST_OWN_ADDRESS   = 8'd2;
  localparam logic [BYTE_W-1:0] RST_PING_CODE     = 8'd1;
  localparam logic [BYTE_W-1:0] RST_POSITION_CODE = 8'd2;
  localparam logic [BYTE_W-1:0] RST_RESET_CODE    = 8'd3;

  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_ADDR    = 5'b00010,
    PH_CMD     = 5'b00100,
    PH_LEN     = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PING  = 2'd0,
    KIND_POS   = 2'd1,
    KIND_RESET = 2'd2
  } kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] own_address;
    logic [BYTE_W-1:0] ping_code;
    logic [BYTE_W-1:0] position_code;
    logic [BYTE_W-1:0] reset_code;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        response_kind;
    logic [BYTE_W-1:0] reply_sequence;
    logic [BYTE_W-1:0] reply_position;
    logic [BYTE_W-1:0] reply_depth;
    logic [WAIT_W-1:0] restart_delay;
    logic              reply_status;
  } resp_t;

endpackage

// ===== rtl/core/cpp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// cpp_cfg_regs
// Configuration register file: start code, own address and command codes.
// ----------------------------------------------------------------------------
module cpp_cfg_regs
  import cpp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_START_CODE:    cfg_nxt.start_code    = cfg_data;
        REG_OWN_ADDRESS:   cfg_nxt.own_address   = cfg_data;
        REG_PING_CODE:     cfg_nxt.ping_code     = cfg_data;
        REG_POSITION_CODE: cfg_nxt.position_code = cfg_data;
        REG_RESET_CODE:    cfg_nxt.reset_code    = cfg_data;
        default:           cfg_nxt = cfg_r; // unused index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code    <= RST_START_CODE;
      cfg_r.own_address   <= RST_OWN_ADDRESS;
      cfg_r.ping_code     <= RST_PING_CODE;
      cfg_r.position_code <= RST_POSITION_CODE;
      cfg_r.reset_code    <= RST_RESET_CODE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/cpp_in_stage.sv =====
// ----------------------------------------------------------------------------
// cpp_in_stage
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module cpp_in_stage
  import cpp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_rx_byte,
  input  logic              advance,
  output logic              stage_valid,
  output logic [BYTE_W-1:0] stage_byte
);

  logic              valid_r;
  logic              valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              load;

  // take a new byte when the stage is empty or drains this cycle
  assign in_ready = !valid_r || advance;
  assign load     = in_valid && in_ready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_rx_byte;
    end
  end

  assign stage_valid = valid_r;
  assign stage_byte  = byte_r;

endmodule

// ===== rtl/core/cpp_parser.sv =====
// ----------------------------------------------------------------------------
// cpp_parser
// Packet framing state machine, payload head store and reply decode.
// One staged byte is consumed per step.
// ----------------------------------------------------------------------------
module cpp_parser
  import cpp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              step,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              res_valid,
  output resp_t             res
);

  phase_t            phase_r, phase_nxt;
  kind_t             cmd_r, cmd_nxt;
  logic [BYTE_W-1:0] len_r, len_nxt;
  logic [BYTE_W-1:0] taken_r, taken_nxt;
  logic [BYTE_W-1:0] pos_r, pos_nxt;
  logic [BYTE_W-1:0] depth_r, depth_nxt;
  logic [BYTE_W-1:0] head_r [HEAD_BYTES];
  logic [BYTE_W-1:0] head_view [HEAD_BYTES];
  logic              head_we;
  logic [BYTE_W-1:0] taken_inc;
  logic              done;

  // the current payload byte lands in the store before the reply is decoded
  assign head_we   = (phase_r == PH_PAYLOAD) && (taken_r < BYTE_W'(HEAD_BYTES));
  assign taken_inc = taken_r + 8'd1;
  assign done      = (phase_r == PH_PAYLOAD) && !(taken_inc < len_r);

  always_comb begin
    for (int i = 0; i < HEAD_BYTES; i++) begin
      head_view[i] = (head_we && (taken_r[HEAD_IDX_W-1:0] == HEAD_IDX_W'(i))) ?
                     rx_byte : head_r[i];
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    taken_nxt = taken_r;
    pos_nxt   = pos_r;
    depth_nxt = depth_r;
    res       = '0;
    res_valid = 1'b0;

    unique case (phase_r)
      PH_HUNT: begin
        if (rx_byte == cfg.start_code) begin
          phase_nxt = PH_ADDR;
        end
      end
      PH_ADDR: begin
        phase_nxt = (rx_byte == cfg.own_address) ? PH_CMD : PH_HUNT;
      end
      PH_CMD: begin
        // equal codes: ping beats position, position beats reset
        priority if (rx_byte == cfg.ping_code) begin
          cmd_nxt   = KIND_PING;
          phase_nxt = PH_LEN;
        end else if (rx_byte == cfg.position_code) begin
          cmd_nxt   = KIND_POS;
          phase_nxt = PH_LEN;
        end else if (rx_byte == cfg.reset_code) begin
          cmd_nxt   = KIND_RESET;
          phase_nxt = PH_LEN;
        end else begin
          phase_nxt = PH_HUNT;
          taken_nxt = '0;
        end
      end
      PH_LEN: begin
        len_nxt   = rx_byte;
        taken_nxt = '0;
        phase_nxt = (rx_byte == '0) ? PH_HUNT : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        taken_nxt = taken_inc;
        if (done) begin
          res_valid          = 1'b1;
          res.response_kind  = cmd_r;
          res.reply_status   = 1'b0;
          unique case (cmd_r)
            KIND_POS: begin
              pos_nxt            = head_view[0];
              depth_nxt          = head_view[1];
              res.reply_sequence = head_view[2] + 8'd1;
            end
            KIND_RESET: begin
              res.restart_delay = {head_view[0], head_view[1],
                                   head_view[2], head_view[3]};
            end
            default: begin
              res.reply_sequence = head_view[1] + 8'd1;
            end
          endcase
          res.reply_position = pos_nxt;
          res.reply_depth    = depth_nxt;
          phase_nxt = PH_HUNT;
          taken_nxt = '0;
          len_nxt   = '0;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        taken_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      cmd_r   <= KIND_PING;
      len_r   <= '0;
      taken_r <= '0;
      pos_r   <= '0;
      depth_r <= '0;
      for (int i = 0; i < HEAD_BYTES; i++) begin
        head_r[i] <= '0;
      end
    end else if (step) begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      taken_r <= taken_nxt;
      pos_r   <= pos_nxt;
      depth_r <= depth_nxt;
      for (int i = 0; i < HEAD_BYTES; i++) begin
        head_r[i] <= head_view[i];
      end
    end
  end

  // inside a payload the count stays below the announced length
  a_taken_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (taken_r < len_r))
    else $error("payload count reached length without closing the packet");

  // a closing step returns to hunting with a cleared count
  a_close_rehunt: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res_valid) |=> (phase_r == PH_HUNT) && (taken_r == '0) && (len_r == '0))
    else $error("parser did not return to hunting after a reply");

  // state only moves on a consumed byte
  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(phase_r) && $stable(taken_r) && $stable(pos_r))
    else $error("parser state changed without a byte");

endmodule

// ===== rtl/core/cpp_out_reg.sv =====
// ----------------------------------------------------------------------------
// cpp_out_reg
// Result register: holds one reply word until the consumer takes it.
// ----------------------------------------------------------------------------
module cpp_out_reg
  import cpp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  load,
  input  resp_t res,
  input  logic  out_ready,
  output logic  out_valid,
  output logic  free,
  output resp_t out_word
);

  logic  valid_r;
  logic  valid_nxt;
  resp_t word_r;

  // free when empty or being taken this cycle
  assign free = !valid_r || out_ready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

// ===== rtl/core/command_packet_parser_top.sv =====
// ----------------------------------------------------------------------------
// command_packet_parser_top
// Frames command packets from a received byte stream and emits one decoded
// reply word per complete packet (ping, set position or delayed reset).
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  in_     | in        | in_valid / in_ready | rx_byte (8)
//  out_    | out       | out_valid/out_ready | kind, sequence, position, depth,
//          |           |                     | restart_delay, reply_status
//  cfg_    | in        | cfg_we (no wait)    | cfg_index (3), cfg_data (8)
//
//  One byte per cycle sustained while the reply word is not stalled. An
//  accepted byte waits in the input register until the parser consumes it;
//  a closing byte's reply loads the result register, which raises out_valid.
//  Reset (rst_n low, synchronous) restores the register defaults and clears
//  the parser, the payload store and the stored position and depth.
//  A stalled reply word holds the parser and the input register; in_ready
//  then drops once the input register is full.
// ----------------------------------------------------------------------------
module command_packet_parser_top
  import cpp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // received bytes
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  // reply words
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_response_kind,
  output logic [BYTE_W-1:0]    out_reply_sequence,
  output logic [BYTE_W-1:0]    out_reply_position,
  output logic [BYTE_W-1:0]    out_reply_depth,
  output logic [WAIT_W-1:0]    out_restart_delay,
  output logic                 out_reply_status,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  cfg_t              cfg;
  logic              advance;
  logic              closes;
  logic              stage_valid;
  logic [BYTE_W-1:0] stage_byte;
  logic              out_free;
  resp_t             res;
  resp_t             out_word;

  cpp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // advance the staged byte whenever the result register can take a word;
  // every byte yields at most one reply, so that is the only condition
  assign advance = stage_valid && out_free;

  cpp_in_stage u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_rx_byte  (in_rx_byte),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_byte  (stage_byte)
  );

  cpp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step      (advance),
    .rx_byte   (stage_byte),
    .res_valid (closes),
    .res       (res)
  );

  // load a reply only for a consumed byte that closes a packet
  cpp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && closes),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (out_free),
    .out_word  (out_word)
  );

  assign out_response_kind  = out_word.response_kind;
  assign out_reply_sequence = out_word.reply_sequence;
  assign out_reply_position = out_word.reply_position;
  assign out_reply_depth    = out_word.reply_depth;
  assign out_restart_delay  = out_word.restart_delay;
  assign out_reply_status   = out_word.reply_status;

  // a staged byte that cannot advance is kept, not lost
  a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_valid && !advance) |=> stage_valid && $stable(stage_byte))
    else $error("staged byte dropped while the result register was full");

  // only reset replies carry a wait time
  a_wait_only_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_response_kind != KIND_RESET)) |-> (out_restart_delay == '0))
    else $error("wait time on a non-reset reply");

  // reset replies carry no sequence
  a_reset_no_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_response_kind == KIND_RESET)) |-> (out_reply_sequence == '0))
    else $error("sequence on a reset reply");

endmodule
